### hdl/jdcd_pkg.sv
package jdcd_pkg;

   localparam int DAY_FIELD_BITS = 32;

   typedef struct packed {
      logic [DAY_FIELD_BITS-1:0] day_number;
      logic [16:0]               day_fraction_seconds;
   } jdcd_req_type;

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } jdcd_rsp_type;

   localparam logic [1:0] MODE_JULIAN     = 2'd0;
   localparam logic [1:0] MODE_GREGORIAN  = 2'd1;
   localparam logic [1:0] MODE_HISTORICAL = 2'd2;

   localparam logic CSR_IDX_MODE = 1'b0;

   localparam int unsigned SWITCH_DAY    = 2299161;
   localparam logic [16:0] SECONDS_LAST  = 17'd86399;

   localparam int unsigned CENTURY_DIV   = 146097;
   localparam int unsigned CENTURY_OFS   = 7468865;
   localparam int unsigned CENTURY_SPLIT = (CENTURY_OFS + 3) / 4;
   localparam int unsigned EPOCH_OFS     = 1524;

   localparam int unsigned YEAR_DIV      = 7305;
   localparam int unsigned YEAR_OFS      = 2442;
   localparam int unsigned YEAR_DAYS4    = 1461;
   localparam int unsigned YEAR_BASE_MAR = 4716;
   localparam int unsigned YEAR_BASE_JAN = 4715;

   localparam int unsigned MONTH_WRAP    = 14;
   localparam int unsigned MONTH_FEB     = 2;

   localparam int unsigned SEC_PER_HOUR  = 3600;
   localparam int unsigned SEC_PER_MIN   = 60;
   localparam int unsigned HOUR_SHIFT    = 29;
   localparam int unsigned HOUR_RECIP    = ((1 << HOUR_SHIFT) + SEC_PER_HOUR - 1) / SEC_PER_HOUR;
   localparam int unsigned MIN_SHIFT     = 18;
   localparam int unsigned MIN_RECIP     = ((1 << MIN_SHIFT) + SEC_PER_MIN - 1) / SEC_PER_MIN;

   // Integer part of 30.6001 * k, the day offset of each month slot.
   localparam logic [8:0] DAY_BASE [0:16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
      9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
   };

endpackage

### hdl/julian_day_to_calendar_date.sv
// One transaction is accepted per cycle while req_stall is low; twelve arithmetic
// stages and an output register with a one-entry skid buffer carry the conversion.
// The skid buffer takes one more result while a result waits on rsp_stall;
// req_stall rises and the pipeline holds once the skid buffer is full.
// Reset is synchronous: it empties the pipeline and the skid buffer and sets
// calendar_mode to the historical switch.
module julian_day_to_calendar_date
   import jdcd_pkg::*;
#(
   parameter int DAY_NUMBER_BITS = 23
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  jdcd_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output jdcd_rsp_type rsp_payload,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int W  = DAY_NUMBER_BITS;
   localparam int BW = W + 1;
   localparam int N1 = W + 2;
   localparam int K1 = W - 14;
   localparam int N2 = W + 6;
   localparam int K2 = W - 2;
   localparam int CW = W - 6;
   localparam int NS = 12;

   localparam logic [63:0] M1_FULL = (64'd1 << N1) / 64'(CENTURY_DIV);
   localparam logic [63:0] M2_FULL = (64'd1 << N2) / 64'(YEAR_DIV);
   localparam logic [K1-1:0] M1 = M1_FULL[K1-1:0];
   localparam logic [CW-1:0] M2 = M2_FULL[CW-1:0];

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clock_time_type;

   typedef struct packed {
      logic [W-1:0]  z;
      logic          greg;
      logic          neg;
      logic [N1-1:0] n1;
      logic [16:0]   secs;
   } st1_type;

   typedef struct packed {
      logic [W-1:0]  z;
      logic          greg;
      logic          neg;
      logic [K1-1:0] q1e;
      logic [19:0]   n1lo;
      logic [4:0]    hour;
      logic [16:0]   secs;
   } st2_type;

   typedef struct packed {
      logic [W-1:0]  z;
      logic          greg;
      logic          neg;
      logic [K1-1:0] q1e;
      logic [19:0]   n1lo;
      logic [19:0]   p1;
      logic [4:0]    hour;
      logic [11:0]   rem;
   } st3_type;

   typedef struct packed {
      logic [W-1:0]  z;
      logic          greg;
      logic          neg;
      logic [K1-1:0] q1;
      logic [4:0]    hour;
      logic [11:0]   rem;
      logic [5:0]    minute;
   } st4_type;

   typedef struct packed {
      logic [BW-1:0]  zb;
      logic           greg;
      logic           neg;
      logic [K1-1:0]  t;
      clock_time_type tm;
   } st5_type;

   typedef struct packed {
      logic [BW-1:0]  b;
      clock_time_type tm;
   } st6_type;

   typedef struct packed {
      logic [N2-1:0]  num2;
      logic [9:0]     b10;
      clock_time_type tm;
   } st7_type;

   typedef struct packed {
      logic [CW-1:0]  q2e;
      logic [15:0]    n2lo;
      logic [9:0]     b10;
      clock_time_type tm;
   } st8_type;

   typedef struct packed {
      logic [CW-1:0]  q2e;
      logic [15:0]    n2lo;
      logic [15:0]    p2;
      logic [9:0]     b10;
      clock_time_type tm;
   } st9_type;

   typedef struct packed {
      logic [CW-1:0]  c;
      logic [9:0]     b10;
      clock_time_type tm;
   } st10_type;

   typedef struct packed {
      logic [8:0]     x;
      logic [15:0]    c16;
      clock_time_type tm;
   } st11_type;

   typedef struct packed {
      logic [4:0]     e;
      logic [8:0]     x;
      logic [15:0]    c16;
      clock_time_type tm;
   } st12_type;

   logic [1:0]    mode_ff, mode_in;
   logic [NS:1]   valid_ff, valid_in;
   logic          pipe_en;
   logic          arrive;

   st1_type  st1_ff,  st1_in;
   st2_type  st2_ff,  st2_in;
   st3_type  st3_ff,  st3_in;
   st4_type  st4_ff,  st4_in;
   st5_type  st5_ff,  st5_in;
   st6_type  st6_ff,  st6_in;
   st7_type  st7_ff,  st7_in;
   st8_type  st8_ff,  st8_in;
   st9_type  st9_ff,  st9_in;
   st10_type st10_ff, st10_in;
   st11_type st11_ff, st11_in;
   st12_type st12_ff, st12_in;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   jdcd_rsp_type out_data_ff, out_data_in;
   jdcd_rsp_type skid_data_ff, skid_data_in;
   jdcd_rsp_type result;

   logic [W-1:0]       z_req;
   logic [N1-1:0]      z_x4;
   logic [2*K1-1:0]    prod1;
   logic [34:0]        prod_h;
   logic [K1+17:0]     prod_p1;
   logic [16:0]        hour_secs;
   logic [16:0]        secs_left;
   logic [19:0]        r1;
   logic [24:0]        prod_m;
   logic [11:0]        min_secs;
   logic [11:0]        sec_left;
   logic [N2-1:0]      b16, b4;
   logic [K2+CW-1:0]   prod2;
   logic [CW+12:0]     prod_p2;
   logic [15:0]        r2;
   logic [22:0]        prod_dd;
   logic [9:0]         x_full;
   logic [15:0]        gt_vec;
   logic [8:0]         day_full;
   logic               month_late;

   // Configuration port.
   assign pready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_IDX_MODE)) begin
         mode_in = pwdata[1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_MODE) begin
         prdata = {30'd0, mode_ff};
      end
   end

   // Pipeline control.
   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign arrive    = pipe_en && valid_ff[NS];
   assign valid_in  = pipe_en ? {valid_ff[NS-1:1], req_valid} : valid_ff;

   // Stage 1: saturation, calendar rule and the century numerator.
   always_comb begin
      z_req = req_payload.day_number[W-1:0];
      z_x4  = {z_req, 2'b00};
      st1_in.z    = z_req;
      st1_in.secs = (req_payload.day_fraction_seconds > SECONDS_LAST) ?
                    SECONDS_LAST : req_payload.day_fraction_seconds;
      case (mode_ff)
         MODE_JULIAN: begin
            st1_in.greg = 1'b0;
         end
         MODE_GREGORIAN: begin
            st1_in.greg = 1'b1;
         end
         default: begin
            st1_in.greg = (z_req >= W'(SWITCH_DAY));
         end
      endcase
      st1_in.neg = (z_req < W'(CENTURY_SPLIT));
      st1_in.n1  = st1_in.neg ? (N1'(CENTURY_OFS) - z_x4) : (z_x4 - N1'(CENTURY_OFS));
   end

   // Stage 2: century quotient estimate and hour.
   always_comb begin
      prod1  = st1_ff.n1[N1-1:16] * M1;
      prod_h = st1_ff.secs * 18'(HOUR_RECIP);
      st2_in.z    = st1_ff.z;
      st2_in.greg = st1_ff.greg;
      st2_in.neg  = st1_ff.neg;
      st2_in.q1e  = prod1[2*K1-1:K1];
      st2_in.n1lo = st1_ff.n1[19:0];
      st2_in.hour = prod_h[HOUR_SHIFT+4:HOUR_SHIFT];
      st2_in.secs = st1_ff.secs;
   end

   // Stage 3: back-multiplied century estimate and seconds within the hour.
   always_comb begin
      prod_p1   = st2_ff.q1e * 18'(CENTURY_DIV);
      hour_secs = 17'(st2_ff.hour) * 17'(SEC_PER_HOUR);
      secs_left = st2_ff.secs - hour_secs;
      st3_in.z    = st2_ff.z;
      st3_in.greg = st2_ff.greg;
      st3_in.neg  = st2_ff.neg;
      st3_in.q1e  = st2_ff.q1e;
      st3_in.n1lo = st2_ff.n1lo;
      st3_in.p1   = prod_p1[19:0];
      st3_in.hour = st2_ff.hour;
      st3_in.rem  = secs_left[11:0];
   end

   // Stage 4: century quotient correction and minute.
   always_comb begin
      r1     = st3_ff.n1lo - st3_ff.p1;
      prod_m = st3_ff.rem * 13'(MIN_RECIP);
      st4_in.z      = st3_ff.z;
      st4_in.greg   = st3_ff.greg;
      st4_in.neg    = st3_ff.neg;
      st4_in.q1     = st3_ff.q1e + K1'(r1 >= 20'(CENTURY_DIV))
                      + K1'(r1 >= 20'(2 * CENTURY_DIV));
      st4_in.hour   = st3_ff.hour;
      st4_in.rem    = st3_ff.rem;
      st4_in.minute = prod_m[MIN_SHIFT+5:MIN_SHIFT];
   end

   // Stage 5: net century correction and second.
   always_comb begin
      min_secs = 12'(st4_ff.minute) * 12'(SEC_PER_MIN);
      sec_left = st4_ff.rem - min_secs;
      st5_in.zb   = {1'b0, st4_ff.z} + (st4_ff.greg ? BW'(EPOCH_OFS + 1) : BW'(EPOCH_OFS));
      st5_in.greg = st4_ff.greg;
      st5_in.neg  = st4_ff.neg;
      st5_in.t    = st4_ff.q1 - (st4_ff.q1 >> 2);
      st5_in.tm.hour   = st4_ff.hour;
      st5_in.tm.minute = st4_ff.minute;
      st5_in.tm.second = sec_left[5:0];
   end

   // Stage 6: shifted day count.
   always_comb begin
      st6_in.b = st5_ff.zb;
      if (st5_ff.greg) begin
         st6_in.b = st5_ff.neg ? (st5_ff.zb - BW'(st5_ff.t)) : (st5_ff.zb + BW'(st5_ff.t));
      end
      st6_in.tm = st5_ff.tm;
   end

   // Stage 7: year numerator.
   always_comb begin
      b16 = N2'({st6_ff.b, 4'b0000});
      b4  = N2'({st6_ff.b, 2'b00});
      st7_in.num2 = b16 + b4 - N2'(YEAR_OFS);
      st7_in.b10  = st6_ff.b[9:0];
      st7_in.tm   = st6_ff.tm;
   end

   // Stage 8: year quotient estimate.
   always_comb begin
      prod2 = st7_ff.num2[N2-1:8] * M2;
      st8_in.q2e  = prod2[K2+CW-1:K2];
      st8_in.n2lo = st7_ff.num2[15:0];
      st8_in.b10  = st7_ff.b10;
      st8_in.tm   = st7_ff.tm;
   end

   // Stage 9: back-multiplied year estimate.
   always_comb begin
      prod_p2 = st8_ff.q2e * 13'(YEAR_DIV);
      st9_in.q2e  = st8_ff.q2e;
      st9_in.n2lo = st8_ff.n2lo;
      st9_in.p2   = prod_p2[15:0];
      st9_in.b10  = st8_ff.b10;
      st9_in.tm   = st8_ff.tm;
   end

   // Stage 10: year quotient correction.
   always_comb begin
      r2 = st9_ff.n2lo - st9_ff.p2;
      st10_in.c   = st9_ff.q2e + CW'(r2 >= 16'(YEAR_DIV)) + CW'(r2 >= 16'(2 * YEAR_DIV));
      st10_in.b10 = st9_ff.b10;
      st10_in.tm  = st9_ff.tm;
   end

   // Stage 11: day within the March-based year. Its value stays below 512, so
   // the low bits of the operands are enough.
   always_comb begin
      prod_dd = st10_ff.c[11:0] * 11'(YEAR_DAYS4);
      x_full  = st10_ff.b10 - prod_dd[11:2];
      st11_in.x   = x_full[8:0];
      st11_in.c16 = st10_ff.c[15:0];
      st11_in.tm  = st10_ff.tm;
   end

   // Stage 12: month slot by comparison against the month offsets.
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         gt_vec[k] = (st11_ff.x > DAY_BASE[k+1]);
      end
      st12_in.e   = 5'($countones(gt_vec));
      st12_in.x   = st11_ff.x;
      st12_in.c16 = st11_ff.c16;
      st12_in.tm  = st11_ff.tm;
   end

   // Final assembly into the output register.
   always_comb begin
      day_full = st12_ff.x - DAY_BASE[st12_ff.e];
      result.day = day_full[4:0];
      if (st12_ff.e < 5'(MONTH_WRAP)) begin
         result.month = 4'(st12_ff.e - 5'd1);
      end else begin
         result.month = 4'(st12_ff.e - 5'(MONTH_WRAP - 1));
      end
      month_late  = (result.month > 4'(MONTH_FEB));
      result.year = month_late ? (st12_ff.c16 - 16'(YEAR_BASE_MAR))
                               : (st12_ff.c16 - 16'(YEAR_BASE_JAN));
      result.hour   = st12_ff.tm.hour;
      result.minute = st12_ff.tm.minute;
      result.second = st12_ff.tm.second;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_stall) begin
         if (arrive) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = arrive;
         out_data_in  = result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_HISTORICAL;
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         valid_ff      <= valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (pipe_en) begin
         st1_ff  <= st1_in;
         st2_ff  <= st2_in;
         st3_ff  <= st3_in;
         st4_ff  <= st4_in;
         st5_ff  <= st5_in;
         st6_ff  <= st6_in;
         st7_ff  <= st7_in;
         st8_ff  <= st8_in;
         st9_ff  <= st9_in;
         st10_ff <= st10_in;
         st11_ff <= st11_in;
         st12_ff <= st12_in;
      end
   end

endmodule

### hdl/jdcd_checker.sv
module jdcd_checker
   import jdcd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input jdcd_req_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input jdcd_rsp_type rsp_payload,
   input logic         psel,
   input logic         penable,
   input logic         pwrite,
   input logic [2:0]   paddr,
   input logic [31:0]  pwdata,
   input logic [31:0]  prdata,
   input logic         pready
);

   logic mode_write;

   assign mode_write = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_MODE);

   // A stalled result transaction stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result transaction changed or was dropped");

   // Reset empties the pipeline and reopens the input.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // The input is held back only while a result waits on the output.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a waiting result");

   // A calendar mode write reads back on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      mode_write ##1 (!(psel && penable && pwrite) && (paddr[2] == CSR_IDX_MODE))
      |-> prdata[1:0] == $past(pwdata[1:0]))
      else $error("calendar mode readback mismatch");

endmodule

bind julian_day_to_calendar_date jdcd_checker u_jdcd_checker (.*);

### verif/tb_julian_day_to_calendar_date.sv
`timescale 1ns / 1ps

module tb_julian_day_to_calendar_date;
   import jdcd_pkg::*;

   localparam int DAY_BITS = 23;
   localparam logic [31:0] DAY_MASK = (32'd1 << DAY_BITS) - 32'd1;
   localparam logic [1:0] MODE_SPARE_CODE = 2'd3;
   localparam logic [2:0] MODE_ADDR = {CSR_IDX_MODE, 2'b00};
   localparam logic [2:0] SPARE_ADDR = {~CSR_IDX_MODE, 2'b00};
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 40;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 300;
   localparam int CORNER_COUNT = 20;

   class date_scoreboard;
      jdcd_rsp_type expected_dates[$];
      logic [1:0] calendar_mode;
      int mismatches;
      int checked;

      function new();
         calendar_mode = MODE_HISTORICAL;
         mismatches = 0;
         checked = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 50) begin
            $display("MISMATCH: %s", what);
         end
      endtask

      function automatic jdcd_rsp_type predict_date(jdcd_req_type item);
         jdcd_rsp_type date;
         longint z, aa, a, b, c, dd, e, dom, mon, yr;
         int unsigned secs;
         bit gregorian;
         z = longint'(item.day_number & DAY_MASK);
         secs = 32'(item.day_fraction_seconds);
         if (secs > SECONDS_LAST) begin
            secs = 32'(SECONDS_LAST);
         end
         case (calendar_mode)
            MODE_JULIAN: begin
               gregorian = 1'b0;
            end
            MODE_GREGORIAN: begin
               gregorian = 1'b1;
            end
            default: begin
               gregorian = (z >= longint'(SWITCH_DAY));
            end
         endcase
         if (gregorian) begin
            aa = (4 * z - 7468865) / 146097;
            a = z + 1 + aa - aa / 4;
         end else begin
            a = z;
         end
         b = a + 1524;
         c = (20 * b - 2442) / 7305;
         dd = (1461 * c) / 4;
         e = (10000 * (b - dd)) / 306001;
         dom = b - dd - (306001 * e) / 10000;
         mon = (e < 14) ? e - 1 : e - 13;
         yr = (mon > 2) ? c - 4716 : c - 4715;
         date.year = yr[15:0];
         date.month = mon[3:0];
         date.day = dom[4:0];
         date.hour = 5'(secs / 3600);
         date.minute = 6'((secs % 3600) / 60);
         date.second = 6'(secs % 60);
         return date;
      endfunction

      function void note_request(jdcd_req_type item);
         expected_dates.push_back(predict_date(item));
      endfunction

      task check_result(jdcd_rsp_type got);
         jdcd_rsp_type want;
         if (expected_dates.size() == 0) begin
            report_mismatch("result arrived with no conversion outstanding");
         end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year) begin
               report_mismatch($sformatf("result %0d year got %0d expected %0d",
                  checked, got.year, want.year));
            end
            if (got.month !== want.month) begin
               report_mismatch($sformatf("result %0d month got %0d expected %0d",
                  checked, got.month, want.month));
            end
            if (got.day !== want.day) begin
               report_mismatch($sformatf("result %0d day got %0d expected %0d",
                  checked, got.day, want.day));
            end
            if (got.hour !== want.hour) begin
               report_mismatch($sformatf("result %0d hour got %0d expected %0d",
                  checked, got.hour, want.hour));
            end
            if (got.minute !== want.minute) begin
               report_mismatch($sformatf("result %0d minute got %0d expected %0d",
                  checked, got.minute, want.minute));
            end
            if (got.second !== want.second) begin
               report_mismatch($sformatf("result %0d second got %0d expected %0d",
                  checked, got.second, want.second));
            end
         end
         checked++;
      endtask

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   jdcd_req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   jdcd_rsp_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   date_scoreboard sb;
   bit sender_gaps;
   bit receiver_gaps;
   bit hold_results;
   int idle_cycles;
   int modes_run;

   logic [31:0] corner_days [CORNER_COUNT] = '{
      32'd0,       32'd1,       32'd2299159, 32'd2299160, 32'd2299161,
      32'd2299162, 32'd8388607, 32'hFFFFFFFF, 32'h12800000, 32'd2451545,
      32'd2451604, 32'd2451605, 32'd2415079, 32'd2415080, 32'd2415020,
      32'd1721424, 32'd1721423, 32'hAA7FFFFF, 32'd2460311, 32'd2488070
   };
   logic [16:0] corner_seconds [CORNER_COUNT] = '{
      17'd0,      17'd86399,  17'd86400,  17'd131071, 17'd59,
      17'd60,     17'd3599,   17'd3600,   17'd43200,  17'd1,
      17'd65536,  17'd86399,  17'd0,      17'd3661,   17'd86340,
      17'd100000, 17'd7199,   17'h1FFFF,  17'd86398,  17'd45296
   };

   julian_day_to_calendar_date #(
      .DAY_NUMBER_BITS(DAY_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_request(req_payload);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_payload);
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: no transaction for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_results = 1'b0;
         end else if (receiver_gaps && $urandom_range(3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic jdcd_req_type random_conversion();
      jdcd_req_type item;
      int unsigned pick;
      pick = $urandom_range(7);
      case (pick)
         0: begin
            case ($urandom_range(4))
               0: item.day_number = 32'd0;
               1: item.day_number = 32'd1;
               2: item.day_number = SWITCH_DAY - 1;
               3: item.day_number = SWITCH_DAY;
               default: item.day_number = DAY_MASK;
            endcase
         end
         1: item.day_number = $urandom();
         2, 3: item.day_number = SWITCH_DAY - 2000 + $urandom_range(4000);
         default: item.day_number = $urandom_range(DAY_MASK);
      endcase
      pick = $urandom_range(7);
      case (pick)
         0: item.day_fraction_seconds = 17'($urandom_range(17'h1FFFF, SECONDS_LAST));
         1: begin
            case ($urandom_range(5))
               0: item.day_fraction_seconds = 17'd0;
               1: item.day_fraction_seconds = 17'd59;
               2: item.day_fraction_seconds = 17'd60;
               3: item.day_fraction_seconds = 17'd3599;
               4: item.day_fraction_seconds = 17'd3600;
               default: item.day_fraction_seconds = SECONDS_LAST;
            endcase
         end
         default: item.day_fraction_seconds = 17'($urandom_range(SECONDS_LAST));
      endcase
      return item;
   endfunction

   task automatic send_conversion(jdcd_req_type item);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (sender_gaps && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_conversion(random_conversion());
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] addr, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == MODE_ADDR) begin
         sb.calendar_mode = value[1:0];
      end
      @(posedge clock);
   endtask

   task automatic read_mode();
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= MODE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {30'd0, sb.calendar_mode}) begin
         sb.report_mismatch($sformatf("calendar_mode read %0h expected %0h",
            prdata, sb.calendar_mode));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_mode(logic [1:0] mode, int count);
      write_register(MODE_ADDR, ($urandom() & ~32'h3) | 32'(mode));
      read_mode();
      send_random(count);
      wait_for_results();
      modes_run++;
   endtask

   initial begin
      jdcd_req_type item;
      sb = new();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      hold_results = 1'b0;
      modes_run = 0;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read_mode();
      for (int i = 0; i < CORNER_COUNT; i++) begin
         item.day_number = corner_days[i];
         item.day_fraction_seconds = corner_seconds[i];
         send_conversion(item);
      end
      wait_for_results();

      write_register(SPARE_ADDR, $urandom());
      read_mode();

      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      run_mode(MODE_JULIAN, PHASE_ITEMS);
      run_mode(MODE_GREGORIAN, PHASE_ITEMS);
      run_mode(MODE_SPARE_CODE, PHASE_ITEMS);

      write_register(MODE_ADDR, 32'(MODE_HISTORICAL));
      read_mode();
      send_random(PHASE_ITEMS);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      hold_results = 1'b1;
      send_random(HOLD_CYCLES);
      send_random(60);
      wait_for_results();
      modes_run++;

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d conversions over %0d calendar mode settings,", sb.checked,
         modes_run + 1);
      $display("with corner days, saturated seconds, wide day numbers and a long output hold.");
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hdl/jdcd_pkg.sv
hdl/julian_day_to_calendar_date.sv
hdl/jdcd_checker.sv
verif/tb_julian_day_to_calendar_date.sv
